### hw/rtl/slcp_pkg.sv
// package for the slcan command line parser
// holds defaults, result kinds, reply bytes, sequencer state type and hex_val
package slcp_pkg;

    localparam int unsigned LINE_LEN_DEF = 33;

    localparam logic [1:0] KIND_REPLY = 2'd0;
    localparam logic [1:0] KIND_FRAME = 2'd1;
    localparam logic [1:0] KIND_OPEN  = 2'd2;
    localparam logic [1:0] KIND_CLOSE = 2'd3;

    localparam logic [7:0] ACK_BYTE  = 8'h0d;
    localparam logic [7:0] NACK_BYTE = 8'h07;

    localparam logic [2:0] BITRATE_RST = 3'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STORE,
        ST_CMD,
        ST_WALK,
        ST_WAIT,
        ST_DONE,
        ST_EMIT
    } t_state;

    // hex digit value, non-hex reads as zero
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
        else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
        else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
        return v;
    endfunction

endpackage

### hw/rtl/slcan_command_line_parser_unit.sv
// slcan command line parser top level: line buffer memory, decode sequencer
// and a result queue; depends on slcp_pkg
//
// usage: host bytes enter on i_rx_byte with i_valid/o_ready, one beat per
// byte. result beats leave on the o_ fields with o_valid/i_ready; o_last
// marks the final result beat caused by an input byte. an input byte that
// causes no result is finished once it is written into the line buffer.
// bytes are stored in a single-port synchronous line buffer memory. a CR
// walks the stored line through the memory one byte per cycle with a
// registered read (ST_CMD, ST_WALK, ST_WAIT) and decodes it in ST_DONE,
// then each result is held one beat at a time in an output register
// (o_valid high) until taken, one beat per cycle at best. a new byte is
// accepted only after all results of the previous one have been taken;
// a stalled receiver holds the block with payload stable.
// reset (synchronous, i_rst_n low) empties the line, sets bitrate 500k and
// timestamps off; the buffer contents stay undefined until written.
// a CR is decoded before its results queue up: at most 6 per byte.
module slcan_command_line_parser_unit #(
    parameter int unsigned LINE_LEN = slcp_pkg::LINE_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_reply_byte,
    output logic [28:0] o_frame_id,
    output logic        o_frame_extended,
    output logic        o_frame_rtr,
    output logic [3:0]  o_frame_dlc,
    output logic [63:0] o_frame_data,
    output logic [2:0]  o_bitrate_sel,
    output logic        o_timestamp_on,
    output logic        o_last
);
    import slcp_pkg::*;

    localparam int unsigned AW = $clog2(LINE_LEN);
    localparam int unsigned CW = $clog2(LINE_LEN + 1);

    logic [7:0] r_mem [LINE_LEN];
    logic [7:0] r_rdata;

    t_state r_state, n_state;
    logic [CW-1:0] r_fill, n_fill;
    logic [7:0]    r_byte;
    logic [2:0]    r_bitrate, n_bitrate;
    logic          r_ts, n_ts;
    logic [CW-1:0] r_idx, n_idx;
    logic [7:0]    r_cmd, n_cmd;
    logic [7:0]    r_arg, n_arg;
    logic [28:0]   r_id, n_id;
    logic [3:0]    r_dlc, n_dlc;
    logic [63:0]   r_data, n_data;
    logic [CW-1:0] r_len, n_len;

    // result queue: small register file read out in order
    logic [2:0]    r_qn, n_qn;
    logic [2:0]    r_qh, n_qh;
    logic [1:0]    r_qk [6];
    logic [7:0]    r_qb [6];
    logic          r_push_frame;

    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic          push;
    logic [1:0]    push_kind;
    logic [7:0]    push_byte;
    logic          frame_ok;
    logic [3:0]    dig;
    logic          ext;
    logic [CW-1:0] head;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_addr] <= r_byte;
        r_rdata <= r_mem[mem_addr];
    end

    assign dig  = hex_val(r_rdata);
    assign ext  = ~r_cmd[5];
    assign head = ext ? CW'(9) : CW'(4);
    assign o_ready = (r_state == ST_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_valid) n_state = ST_STORE;
            ST_STORE: begin
                if (r_fill + CW'(1) == CW'(LINE_LEN)) n_state = ST_EMIT;
                else if (r_byte == ACK_BYTE) n_state = ST_CMD;
                else n_state = ST_IDLE;
            end
            ST_CMD:   n_state = ST_WALK;
            ST_WALK:  if (r_idx + CW'(1) >= r_fill) n_state = ST_WAIT;
            ST_WAIT:  n_state = ST_DONE;
            ST_DONE:  n_state = ST_EMIT;
            ST_EMIT:  if (r_qn == 3'd0 ||
                          (i_ready && r_qh + 3'd1 == r_qn)) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // memory address and write enable
    always_comb begin
        mem_we   = (r_state == ST_STORE);
        mem_addr = AW'(r_fill);
        if (r_state == ST_CMD || r_state == ST_WALK) mem_addr = AW'(r_idx);
    end

    assign frame_ok = (r_len >= head) && (r_dlc <= 4'd8) &&
                      (r_len == head + CW'(1) + CW'({r_dlc, 1'b0}));

    // datapath and decode
    always_comb begin
        n_fill = r_fill; n_bitrate = r_bitrate; n_ts = r_ts;
        n_idx = r_idx; n_cmd = r_cmd; n_arg = r_arg; n_id = r_id;
        n_dlc = r_dlc; n_data = r_data; n_len = r_len;
        n_qn = r_qn; n_qh = r_qh;
        push = 1'b0; push_kind = KIND_REPLY; push_byte = ACK_BYTE;
        case (r_state)
            ST_IDLE: begin
                n_qn = 3'd0; n_qh = 3'd0;
                if (r_fill >= CW'(LINE_LEN)) n_fill = '0;
            end
            ST_STORE: begin
                n_fill = r_fill + CW'(1);
                n_idx  = '0;
                n_len  = r_fill;
                n_id = '0; n_dlc = '0; n_data = '0; n_arg = '0;
                if (r_fill + CW'(1) == CW'(LINE_LEN)) begin
                    push = 1'b1; push_byte = NACK_BYTE; n_fill = '0;
                end
            end
            ST_CMD: n_idx = r_idx + CW'(1);
            ST_WALK, ST_WAIT: begin
                // r_rdata holds the byte at r_idx - 1
                if (r_state == ST_WALK) n_idx = r_idx + CW'(1);
                if (r_idx == CW'(1)) n_cmd = r_rdata;
                else begin
                    if (r_idx == CW'(2)) n_arg = r_rdata;
                    if (r_idx - CW'(1) < head)
                        n_id = ext ? {r_id[24:0], dig} : {18'd0, r_id[6:0], dig};
                    else if (r_idx - CW'(1) == head) n_dlc = dig;
                    else if (r_idx - CW'(1) <= head + CW'(16) && r_idx - CW'(1) < r_len)
                        n_data = {r_data[59:0], dig};
                end
            end
            ST_DONE: begin
                n_fill = '0;
                if (!ext) n_id = {18'd0, r_id[10:0]};
                else n_id = {r_id[28:16] & 13'h1fff, r_id[15:0]};
                // shift data bytes to the top
                if (frame_ok)
                    n_data = r_data << (7'd64 - 7'({r_dlc, 3'b000}));
                if (r_dlc == 4'd0) n_data = '0;
            end
            default: ;
        endcase
        if (r_state == ST_EMIT && o_valid && i_ready) n_qh = r_qh + 3'd1;
        if (r_state == ST_DONE) begin
            case (r_cmd)
                8'h5a: begin
                    if (r_len >= CW'(1) && r_arg == 8'h30) n_ts = 1'b0;
                    else if (r_len >= CW'(1) && r_arg == 8'h31) n_ts = 1'b1;
                end
                8'h53: begin
                    if (r_len >= CW'(1)) begin
                        case (r_arg)
                            8'h33: n_bitrate = 3'd0;
                            8'h34: n_bitrate = 3'd1;
                            8'h35: n_bitrate = 3'd2;
                            8'h36: n_bitrate = 3'd3;
                            8'h38: n_bitrate = 3'd4;
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    // result list built in DONE
    logic [1:0] l_k [6];
    logic [7:0] l_b [6];
    logic [2:0] l_n;
    logic       l_fr;
    logic       s_ok;
    always_comb begin
        for (int i = 0; i < 6; i++) begin
            l_k[i] = KIND_REPLY; l_b[i] = ACK_BYTE;
        end
        l_n = 3'd1; l_fr = 1'b0;
        s_ok = (r_len >= CW'(1)) && (r_arg == 8'h33 || r_arg == 8'h34 ||
               r_arg == 8'h35 || r_arg == 8'h36 || r_arg == 8'h38);
        case (r_cmd)
            8'h4f: begin l_k[0] = KIND_OPEN; l_n = 3'd2; end
            8'h43: begin l_k[0] = KIND_CLOSE; l_n = 3'd2; end
            8'h74, 8'h54, 8'h72, 8'h52: begin
                if (frame_ok) begin l_k[0] = KIND_FRAME; l_n = 3'd2; l_fr = 1'b1; end
            end
            8'h5a: begin
                if (!(r_len >= CW'(1) && (r_arg == 8'h30 || r_arg == 8'h31))) begin
                    l_b[0] = NACK_BYTE; l_n = 3'd2;
                end
            end
            8'h4d, 8'h6d: ;
            8'h53: if (!s_ok) l_b[0] = NACK_BYTE;
            8'h46: begin
                l_b[0] = 8'h46; l_b[1] = 8'h31; l_b[2] = 8'h32; l_n = 3'd4;
            end
            8'h56, 8'h4e: begin
                l_b[0] = r_cmd; l_b[1] = 8'h31; l_b[2] = 8'h32;
                l_b[3] = 8'h33; l_b[4] = 8'h34; l_n = 3'd6;
            end
            default: l_b[0] = NACK_BYTE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_valid) r_byte <= i_rx_byte;
        if (push) begin
            r_qk[0] <= push_kind; r_qb[0] <= push_byte;
        end
        if (r_state == ST_DONE) begin
            for (int i = 0; i < 6; i++) begin
                r_qk[i] <= l_k[i]; r_qb[i] <= l_b[i];
            end
            r_push_frame <= l_fr;
        end
        if (push) r_push_frame <= 1'b0;
        r_idx <= n_idx; r_cmd <= n_cmd; r_arg <= n_arg; r_id <= n_id;
        r_dlc <= n_dlc; r_data <= n_data; r_len <= n_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_fill <= '0; r_bitrate <= BITRATE_RST;
            r_ts <= 1'b0; r_qn <= '0; r_qh <= '0;
        end else begin
            r_state <= n_state; r_fill <= n_fill; r_bitrate <= n_bitrate;
            r_ts <= n_ts; r_qh <= n_qh;
            if (push) r_qn <= 3'd1;
            else if (r_state == ST_DONE) r_qn <= l_n;
            else r_qn <= n_qn;
        end
    end

    // output register view of the queue head
    logic frame_beat;
    assign o_valid = (r_state == ST_EMIT) && (r_qh < r_qn);
    assign frame_beat = (r_qk[r_qh] == KIND_FRAME) && r_push_frame;
    always_comb begin
        o_kind           = r_qk[r_qh];
        o_reply_byte     = (r_qk[r_qh] == KIND_REPLY) ? r_qb[r_qh] : 8'd0;
        o_frame_id       = frame_beat ? r_id : 29'd0;
        o_frame_extended = frame_beat & ext;
        o_frame_rtr      = frame_beat & r_cmd[1];
        o_frame_dlc      = frame_beat ? r_dlc : 4'd0;
        o_frame_data     = frame_beat ? r_data : 64'd0;
        o_bitrate_sel    = r_bitrate;
        o_timestamp_on   = r_ts;
        o_last           = (r_qh + 3'd1 == r_qn);
    end

endmodule
